FILE: rtl/sup_pkg.sv
`default_nettype none
package sup_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int GAIN_W     = 31;
	localparam int MODE_W     = 2;
	localparam int MASK_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int COEF_IDX_W = 7;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

	// Output layouts
	localparam logic [MODE_W-1:0] MODE_2_0_0 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_2_2_0 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_3_2_1 = 2'd2;

	localparam logic [MASK_W-1:0] MASK_2_0_0 = 6'h06;
	localparam logic [MASK_W-1:0] MASK_2_2_0 = 6'h0F;
	localparam logic [MASK_W-1:0] MASK_3_2_1 = 6'h3F;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 31'd1354970623;
	localparam logic [MODE_W-1:0] MODE_RESET = MODE_3_2_1;

	localparam logic signed [SAMPLE_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_W-1:0] S32_MIN = 32'sh8000_0000;

	localparam int COEF_COUNT = 31;

	// Symmetric FIR, Q1.31; entry k weights the sample k steps old
	localparam logic signed [SAMPLE_W-1:0] COEF [COEF_COUNT] = '{
		-32'sd19982143, -32'sd20273109, -32'sd20551464, -32'sd20816192,
		-32'sd21066252, -32'sd21300580, -32'sd21518086, -32'sd21717660,
		-32'sd21898168, -32'sd22058458, -32'sd22197354, -32'sd22313668,
		-32'sd22406189, -32'sd22473694, -32'sd22514946,  32'sd2105121163,
		-32'sd22514946, -32'sd22473694, -32'sd22406189, -32'sd22313668,
		-32'sd22197354, -32'sd22058458, -32'sd21898168, -32'sd21717660,
		-32'sd21518086, -32'sd21300580, -32'sd21066252, -32'sd20816192,
		-32'sd20551464, -32'sd20273109, -32'sd19982143
	};

	// Taps past the table weigh zero
	function automatic logic signed [SAMPLE_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] k);
		logic signed [SAMPLE_W-1:0] c;
		c = '0;
		if (k < COEF_IDX_W'(COEF_COUNT)) begin
			c = COEF[k[4:0]];
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/sup_ifs.sv
`default_nettype none
interface sup_in_if;
	import sup_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;

	modport source (output valid, left_sample, right_sample, input ready);
	modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface sup_out_if;
	import sup_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_ch0;
	logic signed [SAMPLE_W-1:0] out_ch1;
	logic signed [SAMPLE_W-1:0] out_ch2;
	logic signed [SAMPLE_W-1:0] out_ch3;
	logic signed [SAMPLE_W-1:0] out_ch4;
	logic signed [SAMPLE_W-1:0] out_ch5;
	logic [MASK_W-1:0]          channel_mask;

	modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
		channel_mask, input ready);
	modport sink   (input valid, out_ch0, out_ch1, out_ch2, out_ch3, out_ch4, out_ch5,
		channel_mask, output ready);
endinterface

interface sup_cfg_if;
	import sup_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/sup_ram.sv
`default_nettype none
module sup_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/stereo_upmix_fir.sv
`default_nettype none
// Stereo to surround upmix. Each request carries one Q1.31 stereo pair; both samples are
// scaled by the gain register, then laid out as 3_2_1, 2_2_0 or plain stereo (2_0_0, also
// used when enable is 0) and returned as one result with a channel mask. In the upmix
// layouts each side runs a TAPS-tap FIR over its own history RAM: one RAM read and one
// 32x32 multiply per tap per side, both sides in parallel. A new request is taken only
// while idle, so one request is handled at a time; it is taken while the previous
// result still waits at the output. The user must write registers only while the block
// is idle; the block itself does not enforce this.
module stereo_upmix_fir #(
	parameter int TAPS = 31
) (
	input wire logic  clk,
	input wire logic  arst_n,
	sup_in_if.sink    in_ch,
	sup_out_if.source out_ch,
	sup_cfg_if.sink   cfg
);
	import sup_pkg::*;

	localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int FW    = $clog2(TAPS + 1);
	localparam int ACC_W = 34 + $clog2(TAPS);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_GAIN  = 7'b0000010,
		S_WRITE = 7'b0000100,
		S_MAC   = 7'b0001000,
		S_DRAIN = 7'b0010000,
		S_SAT   = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	function automatic logic signed [SAMPLE_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		r = v[SAMPLE_W-1:0];
		if (!v[ACC_W-1] && (|v[ACC_W-2:SAMPLE_W-1])) begin
			r = S32_MAX;
		end else if (v[ACC_W-1] && !(&v[ACC_W-2:SAMPLE_W-1])) begin
			r = S32_MIN;
		end
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_add(input logic signed [SAMPLE_W-1:0] a,
		input logic signed [SAMPLE_W-1:0] b);
		logic signed [SAMPLE_W:0] s;
		logic signed [SAMPLE_W-1:0] r;
		s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
		r = s[SAMPLE_W-1:0];
		if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
			r = s[SAMPLE_W] ? S32_MIN : S32_MAX;
		end
		return r;
	endfunction

	// Configuration
	logic [GAIN_W-1:0] gain_q;
	logic              enable_q;
	logic [MODE_W-1:0] mode_q;

	// Control
	state_t          state_q;
	state_t          state_d;
	logic [AW-1:0]   pos_q;
	logic [FW-1:0]   fill_q;
	logic [AW-1:0]   rd_addr_q;
	logic [AW-1:0]   k_q;
	logic            rd_v_s1;
	logic            mul_v_s2;
	logic            ov_q;

	// Datapath
	logic signed [SAMPLE_W-1:0]   l_q;
	logic signed [SAMPLE_W-1:0]   r_q;
	logic signed [2*SAMPLE_W-1:0] prod_l_q;
	logic signed [2*SAMPLE_W-1:0] prod_r_q;
	logic signed [SAMPLE_W-1:0]   gl_q;
	logic signed [SAMPLE_W-1:0]   gr_q;
	logic                         ok_s1;
	logic signed [SAMPLE_W-1:0]   coef_s1;
	logic signed [ACC_W-1:0]      acc_l_q;
	logic signed [ACC_W-1:0]      acc_r_q;
	logic signed [SAMPLE_W-1:0]   fir_l_q;
	logic signed [SAMPLE_W-1:0]   fir_r_q;

	logic signed [SAMPLE_W-1:0] ch0_q, ch1_q, ch2_q, ch3_q, ch4_q, ch5_q;
	logic [MASK_W-1:0]          mask_q;

	logic                       fir_mode;
	logic                       full_mode;
	logic                       accept;
	logic                       hist_we;
	logic                       load;
	logic signed [SAMPLE_W-1:0] gl_new;
	logic signed [SAMPLE_W-1:0] gr_new;
	logic [SAMPLE_W-1:0]        ram_l_rdata;
	logic [SAMPLE_W-1:0]        ram_r_rdata;
	logic signed [SAMPLE_W-1:0] mul_a_l;
	logic signed [SAMPLE_W-1:0] mul_a_r;
	logic signed [SAMPLE_W-1:0] mul_b;
	logic signed [SAMPLE_W-1:0] ch2_d, ch5_d;

	assign full_mode = enable_q && (mode_q == MODE_3_2_1);
	assign fir_mode  = enable_q && ((mode_q == MODE_3_2_1) || (mode_q == MODE_2_2_0));

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			enable_q <= 1'b1;
			mode_q   <= MODE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_GAIN:   gain_q   <= cfg.data[GAIN_W-1:0];
				REG_ENABLE: enable_q <= cfg.data[0];
				REG_MODE:   mode_q   <= cfg.data[MODE_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (accept) state_d = S_GAIN;
			S_GAIN:  state_d = S_WRITE;
			S_WRITE: state_d = fir_mode ? S_MAC : S_FIN;
			S_MAC:   if (k_q == AW'(TAPS - 1)) state_d = S_DRAIN;
			// the last product lands in the accumulator on the edge that leaves here
			S_DRAIN: if (!rd_v_s1) state_d = S_SAT;
			S_SAT:   state_d = S_FIN;
			S_FIN:   if (load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign gl_new  = prod_l_q[2*SAMPLE_W-2:SAMPLE_W-1];
	assign gr_new  = prod_r_q[2*SAMPLE_W-2:SAMPLE_W-1];
	assign hist_we = (state_q == S_WRITE) && fir_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pos_q     <= '0;
			fill_q    <= '0;
			rd_addr_q <= '0;
			k_q       <= '0;
			rd_v_s1   <= 1'b0;
			mul_v_s2  <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_v_s1  <= (state_q == S_MAC);
			mul_v_s2 <= rd_v_s1;
			if (hist_we) begin
				pos_q     <= (pos_q == AW'(TAPS - 1)) ? '0 : pos_q + AW'(1);
				rd_addr_q <= pos_q;
				k_q       <= '0;
				if (fill_q != FW'(TAPS)) begin
					fill_q <= fill_q + FW'(1);
				end
			end else if (state_q == S_MAC) begin
				// walk back from the newest sample
				rd_addr_q <= (rd_addr_q == '0) ? AW'(TAPS - 1) : rd_addr_q - AW'(1);
				k_q       <= k_q + AW'(1);
			end
		end
	end

	sup_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_left_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (pos_q),
		.wdata (gl_new),
		.raddr (rd_addr_q),
		.rdata (ram_l_rdata)
	);

	sup_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_right_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (pos_q),
		.wdata (gr_new),
		.raddr (rd_addr_q),
		.rdata (ram_r_rdata)
	);

	// Shared multipliers: gain in S_GAIN, tap products otherwise
	always_comb begin
		if (state_q == S_GAIN) begin
			mul_a_l = l_q;
			mul_a_r = r_q;
			mul_b   = $signed({1'b0, gain_q});
		end else begin
			mul_a_l = ok_s1 ? $signed(ram_l_rdata) : '0;
			mul_a_r = ok_s1 ? $signed(ram_r_rdata) : '0;
			mul_b   = coef_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			l_q <= in_ch.left_sample;
			r_q <= in_ch.right_sample;
		end
		// entries not yet written since reset read as zero
		ok_s1    <= FW'(rd_addr_q) < fill_q;
		coef_s1  <= coef_at(COEF_IDX_W'(k_q));
		prod_l_q <= mul_a_l * mul_b;
		prod_r_q <= mul_a_r * mul_b;
		if (state_q == S_WRITE) begin
			gl_q    <= gl_new;
			gr_q    <= gr_new;
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (mul_v_s2) begin
			acc_l_q <= acc_l_q + {{(ACC_W-SAMPLE_W-1){prod_l_q[2*SAMPLE_W-1]}},
				prod_l_q[2*SAMPLE_W-1:SAMPLE_W-1]};
			acc_r_q <= acc_r_q + {{(ACC_W-SAMPLE_W-1){prod_r_q[2*SAMPLE_W-1]}},
				prod_r_q[2*SAMPLE_W-1:SAMPLE_W-1]};
		end
		if (state_q == S_SAT) begin
			fir_l_q <= sat_acc(acc_l_q);
			fir_r_q <= sat_acc(acc_r_q);
		end
	end

	// Result register
	assign load  = (state_q == S_FIN) && (!ov_q || out_ch.ready);
	assign ch2_d = sat_add(gl_q, gr_q);
	assign ch5_d = sat_add(fir_l_q, fir_r_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load) begin
			ov_q <= 1'b1;
		end else if (out_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ch1_q <= gl_q;
			if (full_mode) begin
				ch0_q  <= fir_l_q;
				ch2_q  <= ch2_d;
				ch3_q  <= gr_q;
				ch4_q  <= fir_r_q;
				ch5_q  <= ch5_d;
				mask_q <= MASK_3_2_1;
			end else if (fir_mode) begin
				ch0_q  <= fir_l_q;
				ch2_q  <= gr_q;
				ch3_q  <= fir_r_q;
				ch4_q  <= '0;
				ch5_q  <= '0;
				mask_q <= MASK_2_2_0;
			end else begin
				ch0_q  <= '0;
				ch2_q  <= gr_q;
				ch3_q  <= '0;
				ch4_q  <= '0;
				ch5_q  <= '0;
				mask_q <= MASK_2_0_0;
			end
		end
	end

	assign out_ch.valid        = ov_q;
	assign out_ch.out_ch0      = ch0_q;
	assign out_ch.out_ch1      = ch1_q;
	assign out_ch.out_ch2      = ch2_q;
	assign out_ch.out_ch3      = ch3_q;
	assign out_ch.out_ch4      = ch4_q;
	assign out_ch.out_ch5      = ch5_q;
	assign out_ch.channel_mask = mask_q;

endmodule
`default_nettype wire
